FILE: hdl/rtse_pkg.sv
// Shared types, constants and sizing functions for the treemap size estimator.
// Used by rtse_ctrl, rtse_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package rtse_pkg;

    // Id space geometry.
    localparam int BUCKET_BITS    = 16;
    localparam int ID_W           = 64;
    localparam int BUCKET_W       = ID_W - BUCKET_BITS;
    localparam int KEY_W          = BUCKET_W - BUCKET_BITS;
    localparam int IDS_PER_BUCKET = 1 << BUCKET_BITS;

    // Counter and sum widths.
    localparam int CNT_W  = 17;
    localparam int BODY_W = 14;
    localparam int HDR_W  = 21;
    localparam int CSUM_W = 34;
    localparam int NB_W   = 32;
    localparam int PER_W  = 20;
    localparam int PROD_W = NB_W + PER_W;

    // Store costs in bytes.
    localparam int BITSET_BYTES = 8192;
    localparam int FULL_BODY    = 6;
    localparam int SEG_OVERHEAD = 1 + 4;
    localparam int EMPTY_BYTES  = 8;
    localparam int REPORT_BASE  = EMPTY_BYTES + 4;

    localparam logic [CNT_W-1:0] MAX17    = '1;
    localparam logic [CNT_W-1:0] FULL_IDS = CNT_W'(IDS_PER_BUCKET);

    // Cost of one bitmap whose buckets are all completely covered.
    localparam logic [PER_W-1:0] BULK_PER = PER_W'(4 + (4 + 8 * IDS_PER_BUCKET
        + (IDS_PER_BUCKET + 7) / 8) + FULL_BODY * IDS_PER_BUCKET);

    // Input word kinds.
    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_RANGE   = 2'd1;
    localparam logic [1:0] KIND_SEGMENT = 2'd2;

    // Register map.
    localparam logic REG_COMPARE_FLOOR = 1'b0;

    // Datapath operations.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CLEAR,
        OP_SEG,
        OP_END,
        OP_SETSPAN,
        OP_OPEN,
        OP_ADD_OPEN,
        OP_FRZ_BKT,
        OP_BMP_SUM,
        OP_BMP_ADD,
        OP_FULL_EXTRA,
        OP_BULK_MUL,
        OP_BULK_ADD,
        OP_REP1,
        OP_REP2,
        OP_REP3,
        OP_REP4
    } t_op;

    // Operand selection for pieces and full-bucket runs.
    typedef enum logic [2:0] {
        SRC_FIRST_SINGLE,
        SRC_FIRST,
        SRC_LAST,
        SRC_SPAN_K,
        SRC_RUN_SAME,
        SRC_RUN_TAILK,
        SRC_RUN_M,
        SRC_OPEN_M
    } t_src;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_END,
        S_FIRST,
        S_SPAN_K,
        S_SPAN_CHK,
        S_SPAN_CROSS,
        S_SPAN_BMP,
        S_SPAN_BMP2,
        S_BULK_MUL,
        S_BULK_ADD,
        S_SPAN_OPEN,
        S_LAST,
        S_PIECE,
        S_PIECE_BMP,
        S_PIECE_BMP2,
        S_PIECE_OPEN,
        S_RUN_FRZ,
        S_RUN_EXTRA,
        S_RUN_OPEN,
        S_REP1,
        S_REP2,
        S_REP3,
        S_REP4
    } t_state;

    typedef struct packed {
        t_op  op;
        t_src src;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       len_zero;
        logic       started;
        logic       piece_eq;
        logic       key_eq;
        logic       single;
        logic       gap;
        logic       span_one;
        logic       same_key;
        logic       k_lo_top;
        logic       m_lo_zero;
        logic       nb_zero;
        logic       n_gt1;
        logic       out_free;
    } t_status;

    typedef struct packed {
        logic [BODY_W-1:0] bytes;
        logic              is_run;
    } t_body;

    // Saturating 64-bit add.
    function automatic logic [ID_W-1:0] f_sat_add64(input logic [ID_W-1:0] a,
                                                    input logic [ID_W-1:0] b);
        logic [ID_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ID_W] ? '1 : s[ID_W-1:0];
    endfunction

    // Cheapest store for one bucket; a tie goes to the run store.
    function automatic t_body f_body(input logic [CNT_W-1:0] ids,
                                     input logic [CNT_W-1:0] runs);
        logic [CNT_W:0]   plain_full;
        logic [BODY_W-1:0] plain;
        logic [19:0]      as_run;
        t_body            res;
        plain_full = {ids, 1'b0};
        plain      = (plain_full > (CNT_W+1)'(BITSET_BYTES)) ? BODY_W'(BITSET_BYTES)
                                                             : plain_full[BODY_W-1:0];
        as_run     = 20'd2 + {1'b0, runs, 2'b00};
        res.is_run = (as_run <= {6'b0, plain});
        res.bytes  = res.is_run ? as_run[BODY_W-1:0] : plain;
        return res;
    endfunction

    // Per-bitmap header bytes for a bucket count.
    function automatic logic [HDR_W-1:0] f_header(input logic [CNT_W:0] buckets,
                                                  input logic has_run);
        logic [CNT_W+1:0] plus7;
        logic [HDR_W-1:0] flags;
        logic [HDR_W-1:0] x8;
        logic [HDR_W-1:0] x4;
        logic [HDR_W-1:0] res;
        plus7 = {1'b0, buckets} + (CNT_W+2)'(7);
        flags = HDR_W'(plus7 >> 3);
        x8    = {buckets, 3'b000};
        x4    = {1'b0, buckets, 2'b00};
        if (has_run) begin
            if (buckets >= (CNT_W+1)'(4)) begin
                res = HDR_W'(4) + x8 + flags;
            end else begin
                res = HDR_W'(4) + x4 + flags;
            end
        end else begin
            res = HDR_W'(8) + x8;
        end
        return res;
    endfunction

endpackage

FILE: hdl/roaring_treemap_size_estimator.sv
// Top level: one word in, one size word out. One word is processed at a time: the input
// stalls until the controller is idle again; the result register lets the next word be
// accepted while the previous result waits. Synchronous active-low reset clears the
// controller, the estimator state and the result valid flag, and sets compare_floor to 32.
`timescale 1ns / 1ps

module roaring_treemap_size_estimator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_kind,
    input  logic [rtse_pkg::ID_W-1:0] i_range_base,
    input  logic [rtse_pkg::ID_W-1:0] i_range_length,
    input  logic [31:0]               i_segment_bytes,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [rtse_pkg::ID_W-1:0] o_bitmap_bytes,
    output logic                      o_prefers_bitmap,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [7:0]        r_floor;
    rtse_pkg::t_cmd    w_cmd;
    rtse_pkg::t_status w_status;

    // Configuration register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= 8'd32;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == rtse_pkg::REG_COMPARE_FLOOR)) begin
            r_floor <= pwdata[7:0];
        end
    end

    // Configuration readback; the port never inserts wait states.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rtse_pkg::REG_COMPARE_FLOOR) ? {24'b0, r_floor} : 32'b0;

    rtse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rtse_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_kind           (i_kind),
        .i_range_base     (i_range_base),
        .i_range_length   (i_range_length),
        .i_segment_bytes  (i_segment_bytes),
        .i_compare_floor  (r_floor),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_bitmap_bytes   (o_bitmap_bytes),
        .o_prefers_bitmap (o_prefers_bitmap)
    );

endmodule

FILE: hdl/rtse_ctrl.sv
// Sequencing controller for the treemap size estimator.
// Depends on rtse_pkg; drives rtse_datapath through command and status structs.
`timescale 1ns / 1ps

module rtse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rtse_pkg::t_status i_status,
    output rtse_pkg::t_cmd    o_cmd
);

    rtse_pkg::t_state r_state, n_state;
    rtse_pkg::t_state r_ret, n_ret;
    rtse_pkg::t_src   r_src, n_src;

    // State, operand select and return point registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtse_pkg::S_IDLE;
            r_ret   <= rtse_pkg::S_IDLE;
            r_src   <= rtse_pkg::SRC_FIRST;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_src   <= n_src;
        end
    end

    // A new word is taken only between items.
    assign o_in_stall = (r_state != rtse_pkg::S_IDLE);

    // Next state and datapath command.
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_src     = r_src;
        o_cmd.op  = rtse_pkg::OP_NONE;
        o_cmd.src = r_src;
        unique case (r_state)
            rtse_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = rtse_pkg::OP_CAPTURE;
                    n_state  = rtse_pkg::S_DECODE;
                end
            end
            rtse_pkg::S_DECODE: begin
                n_state = rtse_pkg::S_REP1;
                case (i_status.kind)
                    rtse_pkg::KIND_RESTART: o_cmd.op = rtse_pkg::OP_CLEAR;
                    rtse_pkg::KIND_SEGMENT: o_cmd.op = rtse_pkg::OP_SEG;
                    rtse_pkg::KIND_RANGE: begin
                        if (!i_status.len_zero) begin
                            n_state = rtse_pkg::S_END;
                        end
                    end
                    default: o_cmd.op = rtse_pkg::OP_NONE;
                endcase
            end
            rtse_pkg::S_END: begin
                o_cmd.op = rtse_pkg::OP_END;
                n_state  = rtse_pkg::S_FIRST;
            end
            // Piece in the first bucket; the inner span bounds are set alongside.
            rtse_pkg::S_FIRST: begin
                o_cmd.op = rtse_pkg::OP_SETSPAN;
                n_state  = rtse_pkg::S_PIECE;
                if (i_status.single) begin
                    n_src = rtse_pkg::SRC_FIRST_SINGLE;
                    n_ret = rtse_pkg::S_REP1;
                end else begin
                    n_src = rtse_pkg::SRC_FIRST;
                    n_ret = i_status.gap ? rtse_pkg::S_SPAN_K : rtse_pkg::S_LAST;
                end
            end
            rtse_pkg::S_SPAN_K: begin
                n_src   = rtse_pkg::SRC_SPAN_K;
                n_ret   = rtse_pkg::S_SPAN_CHK;
                n_state = rtse_pkg::S_PIECE;
            end
            // Decide how the covered buckets after the first full one are charged.
            rtse_pkg::S_SPAN_CHK: begin
                if (i_status.span_one) begin
                    n_state = rtse_pkg::S_LAST;
                end else if (i_status.same_key) begin
                    n_src   = rtse_pkg::SRC_RUN_SAME;
                    n_ret   = rtse_pkg::S_LAST;
                    n_state = rtse_pkg::S_RUN_FRZ;
                end else if (!i_status.k_lo_top) begin
                    n_src   = rtse_pkg::SRC_RUN_TAILK;
                    n_ret   = rtse_pkg::S_SPAN_CROSS;
                    n_state = rtse_pkg::S_RUN_FRZ;
                end else begin
                    n_state = rtse_pkg::S_SPAN_CROSS;
                end
            end
            rtse_pkg::S_SPAN_CROSS: begin
                o_cmd.op = rtse_pkg::OP_FRZ_BKT;
                n_state  = rtse_pkg::S_SPAN_BMP;
            end
            rtse_pkg::S_SPAN_BMP: begin
                o_cmd.op = rtse_pkg::OP_BMP_SUM;
                n_state  = rtse_pkg::S_SPAN_BMP2;
            end
            rtse_pkg::S_SPAN_BMP2: begin
                o_cmd.op = rtse_pkg::OP_BMP_ADD;
                n_state  = i_status.nb_zero ? rtse_pkg::S_SPAN_OPEN : rtse_pkg::S_BULK_MUL;
            end
            rtse_pkg::S_BULK_MUL: begin
                o_cmd.op = rtse_pkg::OP_BULK_MUL;
                n_state  = rtse_pkg::S_BULK_ADD;
            end
            rtse_pkg::S_BULK_ADD: begin
                o_cmd.op = rtse_pkg::OP_BULK_ADD;
                n_state  = rtse_pkg::S_SPAN_OPEN;
            end
            rtse_pkg::S_SPAN_OPEN: begin
                o_cmd.op  = rtse_pkg::OP_OPEN;
                o_cmd.src = rtse_pkg::SRC_OPEN_M;
                if (i_status.m_lo_zero) begin
                    n_state = rtse_pkg::S_LAST;
                end else begin
                    n_src   = rtse_pkg::SRC_RUN_M;
                    n_ret   = rtse_pkg::S_LAST;
                    n_state = rtse_pkg::S_RUN_FRZ;
                end
            end
            rtse_pkg::S_LAST: begin
                n_src   = rtse_pkg::SRC_LAST;
                n_ret   = rtse_pkg::S_REP1;
                n_state = rtse_pkg::S_PIECE;
            end
            // Add one piece: open, extend, or close and reopen.
            rtse_pkg::S_PIECE: begin
                if (!i_status.started) begin
                    o_cmd.op = rtse_pkg::OP_OPEN;
                    n_state  = r_ret;
                end else if (i_status.piece_eq) begin
                    o_cmd.op = rtse_pkg::OP_ADD_OPEN;
                    n_state  = r_ret;
                end else begin
                    o_cmd.op = rtse_pkg::OP_FRZ_BKT;
                    n_state  = rtse_pkg::S_PIECE_BMP;
                end
            end
            rtse_pkg::S_PIECE_BMP: begin
                if (i_status.key_eq) begin
                    o_cmd.op = rtse_pkg::OP_OPEN;
                    n_state  = r_ret;
                end else begin
                    o_cmd.op = rtse_pkg::OP_BMP_SUM;
                    n_state  = rtse_pkg::S_PIECE_BMP2;
                end
            end
            rtse_pkg::S_PIECE_BMP2: begin
                o_cmd.op = rtse_pkg::OP_BMP_ADD;
                n_state  = rtse_pkg::S_PIECE_OPEN;
            end
            rtse_pkg::S_PIECE_OPEN: begin
                o_cmd.op = rtse_pkg::OP_OPEN;
                n_state  = r_ret;
            end
            // Run of full buckets inside one bitmap.
            rtse_pkg::S_RUN_FRZ: begin
                o_cmd.op = rtse_pkg::OP_FRZ_BKT;
                n_state  = i_status.n_gt1 ? rtse_pkg::S_RUN_EXTRA : rtse_pkg::S_RUN_OPEN;
            end
            rtse_pkg::S_RUN_EXTRA: begin
                o_cmd.op = rtse_pkg::OP_FULL_EXTRA;
                n_state  = rtse_pkg::S_RUN_OPEN;
            end
            rtse_pkg::S_RUN_OPEN: begin
                o_cmd.op = rtse_pkg::OP_OPEN;
                n_state  = r_ret;
            end
            // Size report.
            rtse_pkg::S_REP1: begin
                o_cmd.op = rtse_pkg::OP_REP1;
                n_state  = rtse_pkg::S_REP2;
            end
            rtse_pkg::S_REP2: begin
                o_cmd.op = rtse_pkg::OP_REP2;
                n_state  = rtse_pkg::S_REP3;
            end
            rtse_pkg::S_REP3: begin
                o_cmd.op = rtse_pkg::OP_REP3;
                n_state  = rtse_pkg::S_REP4;
            end
            rtse_pkg::S_REP4: begin
                if (i_status.out_free) begin
                    o_cmd.op = rtse_pkg::OP_REP4;
                    n_state  = rtse_pkg::S_IDLE;
                end
            end
            default: n_state = rtse_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: hdl/rtse_datapath.sv
// Datapath of the treemap size estimator: estimator state, range split and size report.
// Depends on rtse_pkg; driven by rtse_ctrl.
`timescale 1ns / 1ps

module rtse_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rtse_pkg::t_cmd            i_cmd,
    output rtse_pkg::t_status         o_status,
    input  logic [1:0]                i_kind,
    input  logic [rtse_pkg::ID_W-1:0] i_range_base,
    input  logic [rtse_pkg::ID_W-1:0] i_range_length,
    input  logic [31:0]               i_segment_bytes,
    input  logic [7:0]                i_compare_floor,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic [rtse_pkg::ID_W-1:0] o_bitmap_bytes,
    output logic                      o_prefers_bitmap
);

    localparam int BB = rtse_pkg::BUCKET_BITS;
    localparam int BW = rtse_pkg::BUCKET_W;
    localparam int KW = rtse_pkg::KEY_W;
    localparam int CW = rtse_pkg::CNT_W;

    // Estimator state.
    logic                      r_started;
    logic [KW-1:0]             r_key;
    logic [BW-1:0]             r_bucket;
    logic [CW-1:0]             r_ids;
    logic [CW-1:0]             r_runs;
    logic [31:0]               r_cbody;
    logic                      r_any;
    logic [CW-1:0]             r_count;
    logic [rtse_pkg::ID_W-1:0] r_cbt;
    logic [rtse_pkg::ID_W-1:0] r_rbt;

    // Captured word and working registers.
    logic [1:0]                  r_kind;
    logic [rtse_pkg::ID_W-1:0]   r_base;
    logic [rtse_pkg::ID_W-1:0]   r_len;
    logic [rtse_pkg::ID_W-1:0]   r_lenm1;
    logic [31:0]                 r_seg;
    logic [rtse_pkg::ID_W-1:0]   r_end;
    logic [BW-1:0]               r_k;
    logic [BW-1:0]               r_m;
    logic [rtse_pkg::NB_W-1:0]   r_nb;
    logic [rtse_pkg::PROD_W-1:0] r_prod;
    logic [rtse_pkg::CSUM_W-1:0] r_c;
    logic [rtse_pkg::BODY_W-1:0] r_rbody;
    logic [rtse_pkg::HDR_W-1:0]  r_rhdr;
    logic [rtse_pkg::CSUM_W-1:0] r_s;
    logic [rtse_pkg::ID_W-1:0]   r_bytes;

    // Output register.
    logic                      r_ovalid;
    logic [rtse_pkg::ID_W-1:0] r_obytes;
    logic                      r_opref;

    // Combinational helpers.
    logic [BW-1:0]             w_b0;
    logic [BW-1:0]             w_bl;
    logic [BB-1:0]             w_base_lo;
    logic [BB-1:0]             w_end_lo;
    logic [BB-1:0]             w_k_lo;
    logic [BB-1:0]             w_m_lo;
    logic [BW-1:0]             w_pbucket;
    logic [CW-1:0]             w_pids;
    logic [BB-1:0]             w_pn;
    logic [BB-1:0]             w_nm1;
    logic [18:0]               w_six;
    rtse_pkg::t_body           w_body;
    logic [32:0]               w_cbody_frz;
    logic [32:0]               w_cbody_ext;
    logic [CW:0]               w_ids_sum;
    logic [CW:0]               w_cnt_ext;
    logic [rtse_pkg::ID_W:0]   w_end_sum;
    logic [rtse_pkg::ID_W:0]   w_bytes_ovh;
    logic                      w_pref;

    assign w_b0      = r_base[rtse_pkg::ID_W-1:BB];
    assign w_bl      = r_end[rtse_pkg::ID_W-1:BB];
    assign w_base_lo = r_base[BB-1:0];
    assign w_end_lo  = r_end[BB-1:0];
    assign w_k_lo    = r_k[BB-1:0];
    assign w_m_lo    = r_m[BB-1:0];

    // Operand select: bucket, id count and full-bucket run length.
    always_comb begin
        w_pbucket = r_m;
        w_pids    = rtse_pkg::FULL_IDS;
        w_pn      = '0;
        unique case (i_cmd.src)
            rtse_pkg::SRC_FIRST_SINGLE: begin
                w_pbucket = w_b0;
                w_pids    = {1'b0, w_end_lo} - {1'b0, w_base_lo} + CW'(1);
            end
            rtse_pkg::SRC_FIRST: begin
                w_pbucket = w_b0;
                w_pids    = rtse_pkg::FULL_IDS - {1'b0, w_base_lo};
            end
            rtse_pkg::SRC_LAST: begin
                w_pbucket = w_bl;
                w_pids    = {1'b0, w_end_lo} + CW'(1);
            end
            rtse_pkg::SRC_SPAN_K: begin
                w_pbucket = r_k;
            end
            rtse_pkg::SRC_RUN_SAME: begin
                w_pbucket = r_m;
                w_pn      = w_m_lo - w_k_lo;
            end
            rtse_pkg::SRC_RUN_TAILK: begin
                w_pbucket = {r_k[BW-1:BB], {BB{1'b1}}};
                w_pn      = ~w_k_lo;
            end
            rtse_pkg::SRC_RUN_M: begin
                w_pbucket = r_m;
                w_pn      = w_m_lo;
            end
            rtse_pkg::SRC_OPEN_M: begin
                w_pbucket = {r_m[BW-1:BB], {BB{1'b0}}};
            end
            default: w_pbucket = r_m;
        endcase
    end

    // Arithmetic shared by the state updates and the size report.
    assign w_body      = rtse_pkg::f_body(r_ids, r_runs);
    assign w_cbody_frz = {1'b0, r_cbody} + 33'(w_body.bytes);
    assign w_nm1       = w_pn - BB'(1);
    assign w_six       = {1'b0, w_nm1, 2'b00} + {2'b00, w_nm1, 1'b0};
    assign w_cbody_ext = {1'b0, r_cbody} + {14'b0, w_six};
    assign w_cnt_ext   = {1'b0, r_count} + {2'b00, w_nm1};
    assign w_ids_sum   = {1'b0, r_ids} + {1'b0, w_pids};
    assign w_end_sum   = {1'b0, r_base} + {1'b0, r_lenm1};
    assign w_bytes_ovh = {1'b0, r_bytes} + (rtse_pkg::ID_W+1)'(rtse_pkg::SEG_OVERHEAD);
    assign w_pref      = ({56'b0, i_compare_floor} <= r_rbt)
                         && (w_bytes_ovh < {1'b0, r_rbt});

    // Status to the controller.
    always_comb begin
        o_status.kind      = r_kind;
        o_status.len_zero  = (r_len == '0);
        o_status.started   = r_started;
        o_status.piece_eq  = (w_pbucket == r_bucket);
        o_status.key_eq    = (w_pbucket[BW-1:BB] == r_key);
        o_status.single    = (w_b0 == w_bl);
        o_status.gap       = (w_bl != w_b0 + BW'(1));
        o_status.span_one  = (r_m == r_k);
        o_status.same_key  = (r_m[BW-1:BB] == r_k[BW-1:BB]);
        o_status.k_lo_top  = &w_k_lo;
        o_status.m_lo_zero = (w_m_lo == '0);
        o_status.nb_zero   = (r_nb == '0);
        o_status.n_gt1     = (w_pn > BB'(1));
        o_status.out_free  = !r_ovalid || !i_out_stall;
    end

    // Estimator state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_key     <= '0;
            r_bucket  <= '0;
            r_ids     <= '0;
            r_runs    <= '0;
            r_cbody   <= '0;
            r_any     <= 1'b0;
            r_count   <= '0;
            r_cbt     <= '0;
            r_rbt     <= '0;
        end else begin
            unique case (i_cmd.op)
                rtse_pkg::OP_CLEAR: begin
                    r_started <= 1'b0;
                    r_key     <= '0;
                    r_bucket  <= '0;
                    r_ids     <= '0;
                    r_runs    <= '0;
                    r_cbody   <= '0;
                    r_any     <= 1'b0;
                    r_count   <= '0;
                    r_cbt     <= '0;
                    r_rbt     <= '0;
                end
                rtse_pkg::OP_SEG: begin
                    r_rbt <= rtse_pkg::f_sat_add64(r_rbt, {32'b0, r_seg});
                end
                rtse_pkg::OP_OPEN: begin
                    r_started <= 1'b1;
                    r_key     <= w_pbucket[BW-1:BB];
                    r_bucket  <= w_pbucket;
                    r_ids     <= w_pids;
                    r_runs    <= CW'(1);
                end
                rtse_pkg::OP_ADD_OPEN: begin
                    r_ids  <= w_ids_sum[CW] ? rtse_pkg::MAX17 : w_ids_sum[CW-1:0];
                    r_runs <= (r_runs == rtse_pkg::MAX17) ? rtse_pkg::MAX17
                                                          : r_runs + CW'(1);
                end
                rtse_pkg::OP_FRZ_BKT: begin
                    r_cbody <= w_cbody_frz[32] ? '1 : w_cbody_frz[31:0];
                    r_any   <= r_any | w_body.is_run;
                    r_count <= (r_count == rtse_pkg::MAX17) ? rtse_pkg::MAX17
                                                            : r_count + CW'(1);
                end
                rtse_pkg::OP_BMP_ADD: begin
                    r_cbt   <= rtse_pkg::f_sat_add64(r_cbt, 64'(r_c));
                    r_cbody <= '0;
                    r_any   <= 1'b0;
                    r_count <= '0;
                end
                rtse_pkg::OP_FULL_EXTRA: begin
                    r_cbody <= w_cbody_ext[32] ? '1 : w_cbody_ext[31:0];
                    r_count <= w_cnt_ext[CW] ? rtse_pkg::MAX17 : w_cnt_ext[CW-1:0];
                    r_any   <= 1'b1;
                end
                rtse_pkg::OP_BULK_ADD: begin
                    r_cbt <= rtse_pkg::f_sat_add64(r_cbt, 64'(r_prod));
                end
                default: r_started <= r_started;
            endcase
        end
    end

    // Captured word, range bounds and report pipeline.
    always_ff @(posedge i_clk) begin
        r_nb <= r_m[BW-1:BB] - r_k[BW-1:BB] - rtse_pkg::NB_W'(1);
        unique case (i_cmd.op)
            rtse_pkg::OP_CAPTURE: begin
                r_kind  <= i_kind;
                r_base  <= i_range_base;
                r_len   <= i_range_length;
                r_lenm1 <= i_range_length - rtse_pkg::ID_W'(1);
                r_seg   <= i_segment_bytes;
            end
            rtse_pkg::OP_END: begin
                r_end <= w_end_sum[rtse_pkg::ID_W] ? '1 : w_end_sum[rtse_pkg::ID_W-1:0];
            end
            rtse_pkg::OP_SETSPAN: begin
                r_k <= w_b0 + BW'(1);
                r_m <= w_bl - BW'(1);
            end
            rtse_pkg::OP_BMP_SUM: begin
                r_c <= rtse_pkg::CSUM_W'(4)
                       + rtse_pkg::CSUM_W'(rtse_pkg::f_header({1'b0, r_count}, r_any))
                       + rtse_pkg::CSUM_W'(r_cbody);
            end
            rtse_pkg::OP_BULK_MUL: begin
                r_prod <= rtse_pkg::PROD_W'(r_nb) * rtse_pkg::PROD_W'(rtse_pkg::BULK_PER);
            end
            rtse_pkg::OP_REP1: begin
                r_rbody <= w_body.bytes;
                r_rhdr  <= rtse_pkg::f_header({1'b0, r_count} + (CW+1)'(1),
                                              r_any | w_body.is_run);
            end
            rtse_pkg::OP_REP2: begin
                r_s <= rtse_pkg::CSUM_W'(rtse_pkg::REPORT_BASE)
                       + rtse_pkg::CSUM_W'(r_rhdr)
                       + rtse_pkg::CSUM_W'(r_cbody)
                       + rtse_pkg::CSUM_W'(r_rbody);
            end
            rtse_pkg::OP_REP3: begin
                r_bytes <= r_started ? rtse_pkg::f_sat_add64(r_cbt, 64'(r_s))
                                     : rtse_pkg::ID_W'(rtse_pkg::EMPTY_BYTES);
            end
            rtse_pkg::OP_REP4: begin
                r_obytes <= r_bytes;
                r_opref  <= w_pref;
            end
            default: r_kind <= r_kind;
        endcase
    end

    // Result word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == rtse_pkg::OP_REP4) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_bitmap_bytes   = r_obytes;
    assign o_prefers_bitmap = r_opref;

endmodule
